// ===== design/rta_pkg.sv =====
// Shared constants, codes and structures of the region table allocator.
// Depends on nothing; every other design file refers to it by scoped names.
package rta_pkg;

    localparam int MAX_REGIONS = 16;
    // PAGE_BYTES must be a power of two.
    localparam int PAGE_BYTES  = 4096;
    localparam int PAGE_SHIFT  = $clog2(PAGE_BYTES);

    localparam int IDX_W  = $clog2(MAX_REGIONS);
    localparam int CNT_W  = $clog2(MAX_REGIONS + 1);
    localparam int ADDR_W = 32;
    localparam int SIZE_W = 32;
    localparam int PAGE_W = 21;
    localparam int PREQ_W = SIZE_W + 1 - PAGE_SHIFT;
    localparam int CAP_W  = SIZE_W - PAGE_SHIFT;

    localparam logic [PAGE_W-1:0] PAGE_MAX = '1;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [1:0] {
        MODE_ALLOC   = 2'd0,
        MODE_RELEASE = 2'd1,
        MODE_CHECK   = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_NO_MEM     = 2'd1,
        ST_NOT_FOUND  = 2'd2,
        ST_TABLE_FULL = 2'd3
    } status_t;

    typedef enum logic [0:0] {
        CFG_POOL_BASE = 1'b0,
        CFG_POOL_SIZE = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic [ADDR_W-1:0] pool_base;
        logic [SIZE_W-1:0] pool_size;
    } cfg_t;

    typedef struct packed {
        logic latch;
        logic alloc_check;
        logic alloc_commit;
        logic search_start;
        logic step;
        logic step_shift;
        logic shift_start;
        logic rel_commit;
        logic set_simple;
        logic set_notfound;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic alloc_fail;
        logic scan_done;
        logic found;
    } dp_status_t;

endpackage

// ===== design/rta_if.sv =====
// Handshake channels of the region table allocator: request and result.
// Depends on rta_pkg for the field widths.
interface rta_req_if;
    logic                      valid;
    logic                      ready;
    logic [1:0]                mode;
    logic [rta_pkg::SIZE_W-1:0] request_size;
    logic [rta_pkg::ADDR_W-1:0] address;

    modport source (output valid, output mode, output request_size, output address,
                    input ready);
    modport sink (input valid, input mode, input request_size, input address,
                  output ready);
endinterface

interface rta_rsp_if;
    logic                       valid;
    logic                       ready;
    logic [1:0]                 status;
    logic [rta_pkg::ADDR_W-1:0] region_address;
    logic [rta_pkg::PAGE_W-1:0] page_count;
    logic                       legitimate;

    modport source (output valid, output status, output region_address,
                    output page_count, output legitimate, input ready);
    modport sink (input valid, input status, input region_address,
                  input page_count, input legitimate, output ready);
endinterface

// ===== design/rta_cfg.sv =====
// APB-style register block holding the pool base and pool size.
// Depends on rta_pkg for the register map and the cfg_t structure.
module rta_cfg (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [rta_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [rta_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [rta_pkg::CFG_DATA_W-1:0] prdata,
    output logic                           pready,
    output rta_pkg::cfg_t                  cfg
);

    logic [rta_pkg::ADDR_W-1:0] pool_base_reg;
    logic [rta_pkg::SIZE_W-1:0] pool_size_reg;
    rta_pkg::cfg_reg_t          reg_sel;
    logic                       wr_en;

    assign pready  = 1'b1;
    assign reg_sel = rta_pkg::cfg_reg_t'(paddr[rta_pkg::CFG_ADDR_W-1]);
    assign wr_en   = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pool_base_reg <= '0;
            pool_size_reg <= '0;
        end
        else if (wr_en)
        begin
            unique case (reg_sel)
                rta_pkg::CFG_POOL_BASE: pool_base_reg <= pwdata;
                rta_pkg::CFG_POOL_SIZE: pool_size_reg <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            rta_pkg::CFG_POOL_BASE: prdata = pool_base_reg;
            rta_pkg::CFG_POOL_SIZE: prdata = pool_size_reg;
            default:                prdata = '0;
        endcase
    end

    assign cfg.pool_base = pool_base_reg;
    assign cfg.pool_size = pool_size_reg;

endmodule

// ===== design/rta_ctrl.sv =====
// Sequencer of the region table allocator: handshakes and datapath commands.
// Depends on rta_pkg for the mode codes and the command and status structures.
module rta_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic [1:0]          in_mode,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    input  rta_pkg::dp_status_t dp_status,
    output rta_pkg::cmd_t       cmd
);

    typedef enum logic [6:0] {
        S_IDLE      = 7'b0000001,
        S_ALLOC_CHK = 7'b0000010,
        S_ALLOC_WR  = 7'b0000100,
        S_SEARCH    = 7'b0001000,
        S_SHIFT     = 7'b0010000,
        S_SIMPLE    = 7'b0100000,
        S_FINISH    = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   slot_free;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign slot_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.latch = 1'b1;
                    case (rta_pkg::mode_t'(in_mode))
                        rta_pkg::MODE_ALLOC:   state_next = S_ALLOC_CHK;
                        rta_pkg::MODE_RELEASE:
                        begin
                            cmd.search_start = 1'b1;
                            state_next       = S_SEARCH;
                        end
                        default:               state_next = S_SIMPLE;
                    endcase
                end
            end
            S_ALLOC_CHK:
            begin
                cmd.alloc_check = 1'b1;
                state_next      = dp_status.alloc_fail ? S_FINISH : S_ALLOC_WR;
            end
            S_ALLOC_WR:
            begin
                cmd.alloc_commit = 1'b1;
                state_next       = S_FINISH;
            end
            S_SEARCH:
            begin
                if (dp_status.scan_done)
                begin
                    if (dp_status.found)
                    begin
                        cmd.shift_start = 1'b1;
                        state_next      = S_SHIFT;
                    end
                    else
                    begin
                        cmd.set_notfound = 1'b1;
                        state_next       = S_FINISH;
                    end
                end
                else
                begin
                    cmd.step = 1'b1;
                end
            end
            S_SHIFT:
            begin
                if (dp_status.scan_done)
                begin
                    cmd.rel_commit = 1'b1;
                    state_next     = S_FINISH;
                end
                else
                begin
                    cmd.step       = 1'b1;
                    cmd.step_shift = 1'b1;
                end
            end
            S_SIMPLE:
            begin
                cmd.set_simple = 1'b1;
                state_next     = S_FINISH;
            end
            S_FINISH:
            begin
                if (slot_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== design/rta_dpath.sv =====
// Datapath of the region table allocator: region table memory, page accounting,
// scan pointer, result and output registers. Depends on rta_pkg.
module rta_dpath (
    input  logic                        clk,
    input  logic                        rst_n,
    input  rta_pkg::cmd_t               cmd,
    output rta_pkg::dp_status_t         dp_status,
    input  rta_pkg::cfg_t               cfg,
    input  logic [1:0]                  in_mode,
    input  logic [rta_pkg::SIZE_W-1:0]  in_request_size,
    input  logic [rta_pkg::ADDR_W-1:0]  in_address,
    output logic [1:0]                  out_status,
    output logic [rta_pkg::ADDR_W-1:0]  out_region_address,
    output logic [rta_pkg::PAGE_W-1:0]  out_page_count,
    output logic                        out_legitimate
);

    localparam int ADDR_W = rta_pkg::ADDR_W;
    localparam int PAGE_W = rta_pkg::PAGE_W;
    localparam int IDX_W  = rta_pkg::IDX_W;
    localparam int CNT_W  = rta_pkg::CNT_W;
    localparam int PREQ_W = rta_pkg::PREQ_W;
    localparam int CAP_W  = rta_pkg::CAP_W;
    localparam int SHIFT  = rta_pkg::PAGE_SHIFT;

    // Region table; entry zero is never written and reads as the pool base.
    logic [ADDR_W-1:0] mem_base  [rta_pkg::MAX_REGIONS];
    logic [PAGE_W-1:0] mem_pages [rta_pkg::MAX_REGIONS];

    logic [1:0]        mode_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [PREQ_W-1:0] preq_reg;
    logic [PAGE_W-1:0] room_reg;

    logic [CNT_W-1:0]  count_reg, count_next;
    logic [PAGE_W-1:0] used_reg, used_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic              pend_reg, pend_next;
    logic              found_reg, found_next;
    logic [IDX_W-1:0]  hit_reg, hit_next;
    logic [PAGE_W-1:0] hit_pages_reg, hit_pages_next;

    logic [IDX_W-1:0]  rd_idx, rd_idx_reg;
    logic              rd_zero_reg;
    logic [ADDR_W-1:0] rd_base_reg, rbase;
    logic [PAGE_W-1:0] rd_pages_reg, rpages;

    logic              wr_en;
    logic [IDX_W-1:0]  wr_idx;
    logic [ADDR_W-1:0] wr_base;
    logic [PAGE_W-1:0] wr_pages;

    logic [1:0]        res_status_reg, res_status_next;
    logic [ADDR_W-1:0] res_addr_reg, res_addr_next;
    logic [PAGE_W-1:0] res_pages_reg, res_pages_next;
    logic              res_legit_reg, res_legit_next;

    logic [ADDR_W:0]   req_sum;
    logic [PREQ_W-1:0] preq_in;
    logic [CAP_W-1:0]  cap_raw;
    logic [PAGE_W-1:0] cap;
    logic [PAGE_W-1:0] room_in;
    logic              no_mem;
    logic              table_full;
    logic              idx_live;
    logic [CNT_W-1:0]  cnt_m1;
    logic [ADDR_W:0]   pool_top;
    logic              legit;
    logic [ADDR_W-1:0] new_base;

    assign req_sum = {1'b0, in_request_size} + (ADDR_W + 1)'(rta_pkg::PAGE_BYTES - 1);
    assign preq_in = req_sum[ADDR_W:SHIFT];
    assign cap_raw = cfg.pool_size[rta_pkg::SIZE_W-1:SHIFT];
    assign cap     = (32'(cap_raw) > 32'(rta_pkg::PAGE_MAX)) ? rta_pkg::PAGE_MAX
                                                              : PAGE_W'(cap_raw);
    assign room_in = (cap > used_reg) ? (cap - used_reg) : '0;

    assign no_mem     = (33'(preq_reg) > 33'(room_reg));
    assign table_full = (count_reg >= CNT_W'(rta_pkg::MAX_REGIONS));
    assign idx_live   = (idx_reg < count_reg);
    assign cnt_m1     = count_reg - CNT_W'(1);

    assign pool_top = {1'b0, cfg.pool_base} + {1'b0, cfg.pool_size};
    assign legit    = (rta_pkg::mode_t'(mode_reg) == rta_pkg::MODE_CHECK)
                      && (addr_reg >= cfg.pool_base) && ({1'b0, addr_reg} <= pool_top);

    assign rbase    = rd_zero_reg ? cfg.pool_base : rd_base_reg;
    assign rpages   = rd_zero_reg ? PAGE_W'(1) : rd_pages_reg;
    assign new_base = rbase + (ADDR_W'(rpages) << SHIFT);

    assign dp_status.alloc_fail = no_mem || table_full;
    assign dp_status.scan_done  = !idx_live && !pend_reg;
    assign dp_status.found      = found_reg;

    assign rd_idx = cmd.alloc_check ? cnt_m1[IDX_W-1:0] : idx_reg[IDX_W-1:0];

    always_comb
    begin
        count_next      = count_reg;
        used_next       = used_reg;
        idx_next        = idx_reg;
        pend_next       = 1'b0;
        found_next      = found_reg;
        hit_next        = hit_reg;
        hit_pages_next  = hit_pages_reg;
        res_status_next = res_status_reg;
        res_addr_next   = res_addr_reg;
        res_pages_next  = res_pages_reg;
        res_legit_next  = res_legit_reg;
        wr_en           = 1'b0;
        wr_idx          = count_reg[IDX_W-1:0];
        wr_base         = new_base;
        wr_pages        = PAGE_W'(preq_reg);

        if (cmd.search_start)
        begin
            idx_next   = CNT_W'(1);
            found_next = 1'b0;
        end

        if (cmd.shift_start)
        begin
            idx_next = CNT_W'(hit_reg) + CNT_W'(1);
        end

        if (cmd.step)
        begin
            if (idx_live)
            begin
                pend_next = 1'b1;
                idx_next  = idx_reg + CNT_W'(1);
            end
            if (pend_reg && !cmd.step_shift && (rbase == addr_reg))
            begin
                found_next     = 1'b1;
                hit_next       = rd_idx_reg;
                hit_pages_next = rpages;
            end
            if (pend_reg && cmd.step_shift)
            begin
                wr_en    = 1'b1;
                wr_idx   = rd_idx_reg - IDX_W'(1);
                wr_base  = rd_base_reg;
                wr_pages = rd_pages_reg;
            end
        end

        if (cmd.alloc_check)
        begin
            res_addr_next  = '0;
            res_pages_next = '0;
            res_legit_next = 1'b0;
            res_status_next = no_mem ? rta_pkg::ST_NO_MEM : rta_pkg::ST_TABLE_FULL;
        end

        if (cmd.alloc_commit)
        begin
            wr_en           = 1'b1;
            count_next      = count_reg + CNT_W'(1);
            used_next       = used_reg + PAGE_W'(preq_reg);
            res_status_next = rta_pkg::ST_OK;
            res_addr_next   = new_base;
            res_pages_next  = PAGE_W'(preq_reg);
            res_legit_next  = 1'b0;
        end

        if (cmd.rel_commit)
        begin
            count_next      = cnt_m1;
            used_next       = (used_reg > hit_pages_reg) ? (used_reg - hit_pages_reg) : '0;
            res_status_next = rta_pkg::ST_OK;
            res_addr_next   = addr_reg;
            res_pages_next  = hit_pages_reg;
            res_legit_next  = 1'b0;
        end

        if (cmd.set_notfound)
        begin
            res_status_next = rta_pkg::ST_NOT_FOUND;
            res_addr_next   = '0;
            res_pages_next  = '0;
            res_legit_next  = 1'b0;
        end

        if (cmd.set_simple)
        begin
            res_status_next = rta_pkg::ST_OK;
            res_addr_next   = '0;
            res_pages_next  = '0;
            res_legit_next  = legit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_base[wr_idx]  <= wr_base;
            mem_pages[wr_idx] <= wr_pages;
        end
        rd_base_reg  <= mem_base[rd_idx];
        rd_pages_reg <= mem_pages[rd_idx];
        rd_idx_reg   <= rd_idx;
        rd_zero_reg  <= (rd_idx == '0);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            mode_reg <= in_mode;
            addr_reg <= in_address;
            preq_reg <= preq_in;
            room_reg <= room_in;
        end
        hit_reg        <= hit_next;
        hit_pages_reg  <= hit_pages_next;
        res_status_reg <= res_status_next;
        res_addr_reg   <= res_addr_next;
        res_pages_reg  <= res_pages_next;
        res_legit_reg  <= res_legit_next;
        if (cmd.load_out)
        begin
            out_status         <= res_status_reg;
            out_region_address <= res_addr_reg;
            out_page_count     <= res_pages_reg;
            out_legitimate     <= res_legit_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= CNT_W'(1);
            used_reg  <= PAGE_W'(1);
            idx_reg   <= '0;
            pend_reg  <= 1'b0;
            found_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            used_reg  <= used_next;
            idx_reg   <= idx_next;
            pend_reg  <= pend_next;
            found_reg <= found_next;
        end
    end

endmodule

// ===== design/region_table_allocator_top.sv =====
// Top level of the region table allocator: register block, sequencer, datapath.
// Depends on rta_pkg, rta_if, rta_cfg, rta_ctrl and rta_dpath.
//
//   Channel  Direction  Handshake               Contents
//   req      in         valid/ready             mode, request_size, address
//   rsp      out        valid/ready             status, region_address, page_count,
//                                               legitimate
//   apb      in/out     psel/penable, pready=1  pool_base (0x0), pool_size (0x4)
//
// A release makes one pass over the table to find the base and one to close the gap,
// each one entry a cycle through the table memory, which reads one entry and writes
// one per cycle.
// Reset restores a table holding only the first page.
// A finished result waits in the output register while the next request is
// taken; the sequencer stalls only if a second result is ready before then.
module region_table_allocator_top (
    input  logic                           clk,
    input  logic                           rst_n,
    rta_req_if.sink                        req,
    rta_rsp_if.source                      rsp,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [rta_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [rta_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [rta_pkg::CFG_DATA_W-1:0] prdata,
    output logic                           pready
);

    rta_pkg::cfg_t       cfg;
    rta_pkg::cmd_t       cmd;
    rta_pkg::dp_status_t dp_status;

    rta_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    rta_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_mode   (req.mode),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .dp_status (dp_status),
        .cmd       (cmd)
    );

    rta_dpath u_dpath (
        .clk                (clk),
        .rst_n              (rst_n),
        .cmd                (cmd),
        .dp_status          (dp_status),
        .cfg                (cfg),
        .in_mode            (req.mode),
        .in_request_size    (req.request_size),
        .in_address         (req.address),
        .out_status         (rsp.status),
        .out_region_address (rsp.region_address),
        .out_page_count     (rsp.page_count),
        .out_legitimate     (rsp.legitimate)
    );

endmodule
